/* design/hle_pkg.sv */
// ---------------------------------------------------------------------------
// Holiday list extractor package
// Shared types, constants and helper functions for the extractor block.
// ---------------------------------------------------------------------------
package hle_pkg;

    localparam int MaxEntriesDef = 64;
    localparam int NameSlotDef   = 32;
    localparam int ResultLimit   = 31;

    localparam logic [2:0] OP_BYTE  = 3'd0;
    localparam logic [2:0] OP_END   = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_QUERY = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_ENTRY = 2'd2;
    localparam logic [1:0] KIND_RANGE = 2'd3;

    typedef enum logic [1:0] {
        PH_SEEK_DATE = 2'd0,
        PH_DATE      = 2'd1,
        PH_SEEK_NAME = 2'd2,
        PH_NAME      = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_SCAN  = 3'd1,
        ST_QOUT  = 3'd2,
        ST_RWAIT = 3'd3,
        ST_ROUT  = 3'd4,
        ST_SOUT  = 3'd5
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic do_byte;
        logic do_end;
        logic do_clear;
        logic scan_start;
        logic scan_step;
        logic read_start;
        logic read_step;
        logic out_load;
        logic [1:0] out_kind;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic read_empty;
        logic read_last;
        logic read_range;
    } t_stat;

    // Character of key "date":" or "name":" at a position.
    function automatic logic [7:0] key_char(input logic is_name, input logic [2:0] p);
        logic [7:0] c;
        begin
            case (p)
                3'd0: c = 8'h22;
                3'd1: c = is_name ? 8'h6e : 8'h64;
                3'd2: c = 8'h61;
                3'd3: c = is_name ? 8'h6d : 8'h74;
                3'd4: c = 8'h65;
                3'd5: c = 8'h22;
                3'd6: c = 8'h3a;
                3'd7: c = 8'h22;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // Key match advance. The only inner overlap of the keys is the quote:
    // after six matched characters the text ends in the key's second quote,
    // so the key's second character continues a match of two. Otherwise a
    // failed match restarts at one on a quote and zero on anything else.
    function automatic logic [3:0] key_adv(input logic is_name, input logic [3:0] p,
                                           input logic [7:0] c);
        logic [3:0] r;
        begin
            if (c == key_char(is_name, p[2:0]) && p < 4'd8) begin
                r = p + 4'd1;
            end else if (p == 4'd6 && c == key_char(is_name, 3'd1)) begin
                r = 4'd2;
            end else if (c == 8'h22) begin
                r = 4'd1;
            end else begin
                r = 4'd0;
            end
            return r;
        end
    endfunction

endpackage

/* design/hle_if.sv */
// ---------------------------------------------------------------------------
// Holiday list extractor channels
// Valid/ready channel interfaces for request and result items.
// ---------------------------------------------------------------------------
interface hle_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [7:0]  data_byte;
    logic [13:0] query_year;
    logic [3:0]  query_month;
    logic [4:0]  query_day;
    logic [6:0]  entry_index;
    modport source (output valid, opcode, data_byte, query_year, query_month,
                    query_day, entry_index, input ready);
    modport sink (input valid, opcode, data_byte, query_year, query_month,
                  query_day, entry_index, output ready);
endinterface

interface hle_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [6:0]  entry_count;
    logic [6:0]  first_index;
    logic        day_hit;
    logic [5:0]  hit_index;
    logic [13:0] entry_year;
    logic [3:0]  entry_month;
    logic [4:0]  entry_day;
    logic [6:0]  name_char;
    logic        last;
    modport source (output valid, kind, entry_count, first_index, day_hit, hit_index,
                    entry_year, entry_month, entry_day, name_char, last, input ready);
    modport sink (input valid, kind, entry_count, first_index, day_hit, hit_index,
                  entry_year, entry_month, entry_day, name_char, last, output ready);
endinterface

/* design/hle_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
module hle_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* design/hle_ctrl.sv */
// ---------------------------------------------------------------------------
// Holiday list extractor controller
// Sequences each request: byte parse, acks, table scan and entry read-out.
// ---------------------------------------------------------------------------
module hle_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [2:0]       i_opcode,
    output logic             o_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  hle_pkg::t_stat   i_stat,
    output hle_pkg::t_cmd    o_cmd
);
    import hle_pkg::*;

    t_state r_state, n_state;
    logic   acc;
    logic   fire;

    assign o_ready     = (r_state == ST_IDLE);
    assign acc         = i_valid && o_ready;
    assign o_out_valid = (r_state == ST_QOUT) || (r_state == ST_ROUT) || (r_state == ST_SOUT);
    assign fire        = o_out_valid && i_out_ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    case (i_opcode)
                        OP_END, OP_CLEAR: n_state = ST_SOUT;
                        OP_QUERY:         n_state = ST_SCAN;
                        OP_READ:          n_state = ST_RWAIT;
                        default:          n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:  if (i_stat.scan_done) n_state = ST_QOUT;
            ST_RWAIT: n_state = ST_ROUT;
            ST_ROUT: begin
                if (fire && i_stat.read_last) n_state = ST_IDLE;
                else if (fire) n_state = ST_RWAIT;
            end
            ST_QOUT, ST_SOUT: if (fire) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    o_cmd.do_byte    = (i_opcode == OP_BYTE);
                    o_cmd.do_end     = (i_opcode == OP_END);
                    o_cmd.do_clear   = (i_opcode == OP_CLEAR);
                    o_cmd.scan_start = (i_opcode == OP_QUERY);
                    o_cmd.read_start = (i_opcode == OP_READ);
                end
            end
            ST_SCAN: o_cmd.scan_step = 1'b1;
            ST_RWAIT: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_kind = i_stat.read_range ? KIND_RANGE : KIND_ENTRY;
            end
            ST_ROUT: o_cmd.read_step = fire;
            default: o_cmd = '0;
        endcase
    end
endmodule

/* design/hle_dp.sv */
// ---------------------------------------------------------------------------
// Holiday list extractor datapath
// Byte parser, entry tables, query scanner and read-out registers.
// ---------------------------------------------------------------------------
module hle_dp #(
    parameter int MaxEntries = hle_pkg::MaxEntriesDef,
    parameter int NameSlot   = hle_pkg::NameSlotDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hle_pkg::t_cmd  i_cmd,
    output hle_pkg::t_stat o_stat,
    input  logic [7:0]     i_data_byte,
    input  logic [13:0]    i_query_year,
    input  logic [3:0]     i_query_month,
    input  logic [4:0]     i_query_day,
    input  logic [6:0]     i_entry_index,
    output logic [1:0]     o_kind,
    output logic [6:0]     o_entry_count,
    output logic [6:0]     o_first_index,
    output logic           o_day_hit,
    output logic [5:0]     o_hit_index,
    output logic [13:0]    o_entry_year,
    output logic [3:0]     o_entry_month,
    output logic [4:0]     o_entry_day,
    output logic [6:0]     o_name_char,
    output logic           o_last
);
    import hle_pkg::*;

    localparam int IW      = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
    localparam int CW      = $clog2(MaxEntries + 1);
    localparam int NameCap = NameSlot - 1;
    localparam int FW      = $clog2(NameSlot);
    localparam int CharDep = MaxEntries * NameCap;
    localparam int AW      = $clog2(CharDep);
    localparam int DW      = 14 + 4 + 5 + FW;

    // Parser state.
    t_phase        r_phase;
    logic [3:0]    r_kpos;
    logic [3:0]    r_dcnt;
    logic [13:0]   r_py;
    logic [3:0]    r_pm;
    logic [4:0]    r_pd;
    logic          r_dok;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] r_trim;
    logic [CW-1:0] r_count;
    logic          r_full;

    logic [3:0]    dig;
    logic          isdig;
    logic          close_ok;
    logic          ch_wr;
    logic [AW-1:0] ch_waddr;
    logic          full_now;

    assign isdig    = (i_data_byte >= 8'h30) && (i_data_byte <= 8'h39);
    assign dig      = isdig ? 4'(i_data_byte - 8'h30) : 4'd0;
    assign full_now = r_full || (r_count >= CW'(MaxEntries));
    assign close_ok = r_dok && (r_trim != '0) && (r_count < CW'(MaxEntries));
    assign ch_wr    = i_cmd.do_byte && !full_now && (r_phase == PH_NAME) &&
                      (i_data_byte != 8'h22) && (i_data_byte >= 8'd32) &&
                      (i_data_byte <= 8'd126) && (r_fill < FW'(NameCap));
    assign ch_waddr = AW'(r_count[IW-1:0] * NameCap) + AW'(r_fill);

    // Byte parser and table count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK_DATE;
            r_kpos  <= '0;
            r_dcnt  <= '0;
            r_py    <= '0;
            r_pm    <= '0;
            r_pd    <= '0;
            r_dok   <= 1'b1;
            r_fill  <= '0;
            r_trim  <= '0;
            r_count <= '0;
            r_full  <= 1'b0;
        end else if (i_cmd.do_end || i_cmd.do_clear) begin
            r_phase <= PH_SEEK_DATE;
            r_kpos  <= '0;
            r_dcnt  <= '0;
            r_py    <= '0;
            r_pm    <= '0;
            r_pd    <= '0;
            r_dok   <= 1'b1;
            r_fill  <= '0;
            r_trim  <= '0;
            if (i_cmd.do_clear) begin
                r_count <= '0;
                r_full  <= 1'b0;
            end
        end else if (i_cmd.do_byte && !full_now) begin
            case (r_phase)
                PH_SEEK_DATE: begin
                    if (key_adv(1'b0, r_kpos, i_data_byte) == 4'd8) begin
                        r_phase <= PH_DATE;
                        r_kpos  <= '0;
                        r_dcnt  <= '0;
                        r_py    <= '0;
                        r_pm    <= '0;
                        r_pd    <= '0;
                        r_dok   <= 1'b1;
                    end else begin
                        r_kpos <= key_adv(1'b0, r_kpos, i_data_byte);
                    end
                end
                PH_DATE: begin
                    if (r_dcnt != 4'd4 && r_dcnt != 4'd7 && !isdig) r_dok <= 1'b0;
                    if (r_dcnt < 4'd4) begin
                        r_py <= 14'(r_py * 14'd10) + 14'(dig);
                    end else if (r_dcnt == 4'd5) begin
                        if (dig > 4'd1) begin
                            r_dok <= 1'b0;
                            r_pm  <= '0;
                        end else begin
                            r_pm <= (dig == 4'd1) ? 4'd10 : 4'd0;
                        end
                    end else if (r_dcnt == 4'd6) begin
                        if (5'(dig) + 5'(r_pm) < 5'd1 || 5'(dig) + 5'(r_pm) > 5'd12) begin
                            r_dok <= 1'b0;
                            r_pm  <= '0;
                        end else begin
                            r_pm <= dig + r_pm;
                        end
                    end else if (r_dcnt == 4'd8) begin
                        if (dig > 4'd3) begin
                            r_dok <= 1'b0;
                            r_pd  <= '0;
                        end else begin
                            r_pd <= 5'(dig) * 5'd10;
                        end
                    end else if (r_dcnt == 4'd9) begin
                        if (6'(dig) + 6'(r_pd) < 6'd1 || 6'(dig) + 6'(r_pd) > 6'd31) begin
                            r_dok <= 1'b0;
                            r_pd  <= '0;
                        end else begin
                            r_pd <= 5'(dig) + r_pd;
                        end
                    end
                    if (r_dcnt == 4'd9) begin
                        r_phase <= PH_SEEK_NAME;
                        r_kpos  <= '0;
                        r_dcnt  <= '0;
                    end else begin
                        r_dcnt <= r_dcnt + 4'd1;
                    end
                end
                PH_SEEK_NAME: begin
                    if (key_adv(1'b1, r_kpos, i_data_byte) == 4'd8) begin
                        r_phase <= PH_NAME;
                        r_kpos  <= '0;
                        r_fill  <= '0;
                        r_trim  <= '0;
                    end else begin
                        r_kpos <= key_adv(1'b1, r_kpos, i_data_byte);
                    end
                end
                default: begin
                    if (i_data_byte == 8'h22) begin
                        if (close_ok) begin
                            r_count <= r_count + CW'(1);
                            if (r_count + CW'(1) >= CW'(MaxEntries)) r_full <= 1'b1;
                        end
                        r_phase <= PH_SEEK_DATE;
                        r_kpos  <= 4'd1;
                        r_dcnt  <= '0;
                        r_py    <= '0;
                        r_pm    <= '0;
                        r_pd    <= '0;
                        r_dok   <= 1'b1;
                        r_fill  <= '0;
                        r_trim  <= '0;
                    end else if (ch_wr) begin
                        r_fill <= r_fill + FW'(1);
                        if (i_data_byte != 8'h20) r_trim <= r_fill + FW'(1);
                    end
                end
            endcase
        end
    end

    // Entry tables: date and length in one memory, name characters in another.
    logic          dt_we;
    logic [IW-1:0] dt_raddr;
    logic [DW-1:0] dt_rdata;
    logic [AW-1:0] ch_raddr;
    logic [6:0]    ch_rdata;

    assign dt_we = i_cmd.do_byte && !full_now && (r_phase == PH_NAME) &&
                   (i_data_byte == 8'h22) && close_ok;

    hle_ram #(.Width(DW), .Depth(MaxEntries)) u_date_ram (
        .i_clk   (i_clk),
        .i_we    (dt_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata ({r_py, r_pm, r_pd, r_trim}),
        .i_raddr (dt_raddr),
        .o_rdata (dt_rdata)
    );

    hle_ram #(.Width(7), .Depth(CharDep)) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (ch_wr),
        .i_waddr (ch_waddr),
        .i_wdata (i_data_byte[6:0]),
        .i_raddr (ch_raddr),
        .o_rdata (ch_rdata)
    );

    logic [13:0] rd_y;
    logic [3:0]  rd_m;
    logic [4:0]  rd_d;
    logic [FW-1:0] rd_len;
    assign {rd_y, rd_m, rd_d, rd_len} = dt_rdata;

    // Query scan: one entry per cycle, key product registered.
    logic [CW-1:0]  r_sidx;
    logic           r_svld;
    logic [CW-1:0]  r_pidx;
    logic [13:0]    r_qy;
    logic [3:0]     r_qm;
    logic [4:0]     r_qd;
    logic [22:0]    r_qkey;
    logic [CW-1:0]  r_first;
    logic           r_hit;
    logic [IW-1:0]  r_hidx;
    logic           r_done;
    logic [22:0]    ekey;

    assign ekey = 23'((23'(rd_y) * 23'd12 + 23'(rd_m)) * 23'd31) + 23'(rd_d);

    // Read-out state.
    logic [IW-1:0] r_ridx;
    logic          r_range;
    logic [4:0]    r_rpos;
    logic [4:0]    rlen;

    assign rlen = (32'(rd_len) > ResultLimit) ? 5'(ResultLimit) : 5'(rd_len);

    always_comb begin
        dt_raddr = r_sidx[IW-1:0];
        if (i_cmd.read_start || i_cmd.read_step || !i_cmd.scan_step) dt_raddr = r_ridx;
        if (i_cmd.read_start) dt_raddr = i_entry_index[IW-1:0];
        if (i_cmd.scan_start) dt_raddr = '0;
    end

    // The first character of a read is fetched together with its date.
    assign ch_raddr = i_cmd.read_start ? AW'(i_entry_index[IW-1:0] * NameCap) :
                      AW'(r_ridx * NameCap) + AW'(r_rpos + 5'(i_cmd.read_step));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sidx  <= '0;
            r_svld  <= 1'b0;
            r_done  <= 1'b0;
            r_rpos  <= '0;
            r_ridx  <= '0;
            r_range <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_qy    <= i_query_year;
                r_qm    <= i_query_month;
                r_qd    <= i_query_day;
                r_qkey  <= 23'((23'(i_query_year) * 23'd12 + 23'(i_query_month)) * 23'd31)
                           + 23'(i_query_day);
                r_first <= r_count;
                r_hit   <= 1'b0;
                r_hidx  <= '0;
                r_sidx  <= CW'(1);
                r_pidx  <= '0;
                r_svld  <= (r_count != '0);
                r_done  <= (r_count == '0);
            end else if (i_cmd.scan_step && !r_done) begin
                if (r_svld) begin
                    if (r_first == r_count && ekey >= r_qkey) r_first <= r_pidx;
                    if (!r_hit && rd_y == r_qy && rd_m == r_qm && rd_d == r_qd) begin
                        r_hit  <= 1'b1;
                        r_hidx <= r_pidx[IW-1:0];
                    end
                end
                r_pidx <= r_sidx;
                r_svld <= (r_sidx < r_count);
                r_sidx <= r_sidx + CW'(1);
                r_done <= (r_sidx >= r_count);
            end
            if (i_cmd.read_start) begin
                r_ridx  <= i_entry_index[IW-1:0];
                r_range <= (CW'(i_entry_index) >= r_count) || (i_entry_index >= 7'(MaxEntries))
                           || (7'(CW'(i_entry_index)) != i_entry_index);
                r_rpos  <= '0;
            end else if (i_cmd.read_step) begin
                r_rpos <= r_rpos + 5'd1;
            end
        end
    end

    assign o_stat.scan_done  = r_done;
    assign o_stat.read_range = r_range;
    assign o_stat.read_empty = (rlen == '0);
    assign o_stat.read_last  = r_range || (rlen == '0) || (r_rpos + 5'd1 >= rlen);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_end || i_cmd.do_clear) begin
            o_kind        <= KIND_ACK;
            o_entry_count <= i_cmd.do_clear ? 7'd0 : 7'(r_count);
            o_first_index <= '0;
            o_day_hit     <= 1'b0;
            o_hit_index   <= '0;
            o_entry_year  <= '0;
            o_entry_month <= '0;
            o_entry_day   <= '0;
            o_name_char   <= '0;
            o_last        <= 1'b1;
        end else if (i_cmd.scan_step && r_done) begin
            o_kind        <= KIND_QUERY;
            o_entry_count <= 7'(r_count);
            o_first_index <= 7'(r_first);
            o_day_hit     <= r_hit;
            o_hit_index   <= 6'(r_hidx);
            o_entry_year  <= '0;
            o_entry_month <= '0;
            o_entry_day   <= '0;
            o_name_char   <= '0;
            o_last        <= 1'b1;
        end else if (i_cmd.out_load) begin
            o_kind        <= i_cmd.out_kind;
            o_entry_count <= 7'(r_count);
            o_first_index <= '0;
            o_day_hit     <= 1'b0;
            o_hit_index   <= '0;
            o_entry_year  <= r_range ? 14'd0 : rd_y;
            o_entry_month <= r_range ? 4'd0 : rd_m;
            o_entry_day   <= r_range ? 5'd0 : rd_d;
            o_name_char   <= (r_range || rlen == '0) ? 7'd0 : ch_rdata;
            o_last        <= o_stat.read_last;
        end
    end
endmodule

/* design/holiday_list_extractor_core.sv */
// ---------------------------------------------------------------------------
// Holiday list extractor core
// Parses a JSON holiday reply into a date/name table and answers lookups.
// ---------------------------------------------------------------------------
// Usage: requests arrive on the input channel; results leave on the output
// channel with last marking the final result of each request.
// A body byte gives no result; the parser handles one
// byte per accepted request, so bytes stream at one per cycle while no
// result is pending.
// End of body and clear table give one count ack in the cycle after acceptance.
// A date query walks the table through the date memory's read port, one
// entry per cycle, and then gives its answer.
// A read gives up to 31 results, one per name character, each fetched through
// the registered read of the character memory once the previous one is taken.
// The block takes a new request once the last result of the previous one
// has been taken; while the receiver stalls, the result is held steady.
// Reset clears the parser and empties the table; no clearing pass is needed.
// ---------------------------------------------------------------------------
module holiday_list_extractor_core #(
    parameter int MaxEntries = hle_pkg::MaxEntriesDef,
    parameter int NameSlot   = hle_pkg::NameSlotDef
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    hle_in_if.sink    in_ch,
    hle_out_if.source out_ch
);
    import hle_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    hle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_ch.valid),
        .i_opcode    (in_ch.opcode),
        .o_ready     (in_ch.ready),
        .i_out_ready (out_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    hle_dp #(.MaxEntries(MaxEntries), .NameSlot(NameSlot)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_data_byte   (in_ch.data_byte),
        .i_query_year  (in_ch.query_year),
        .i_query_month (in_ch.query_month),
        .i_query_day   (in_ch.query_day),
        .i_entry_index (in_ch.entry_index),
        .o_kind        (out_ch.kind),
        .o_entry_count (out_ch.entry_count),
        .o_first_index (out_ch.first_index),
        .o_day_hit     (out_ch.day_hit),
        .o_hit_index   (out_ch.hit_index),
        .o_entry_year  (out_ch.entry_year),
        .o_entry_month (out_ch.entry_month),
        .o_entry_day   (out_ch.entry_day),
        .o_name_char   (out_ch.name_char),
        .o_last        (out_ch.last)
    );
endmodule

/* design/hle_checker.sv */
// ---------------------------------------------------------------------------
// Holiday list extractor checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
module hle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_kind,
    input logic [6:0]  i_count,
    input logic [6:0]  i_first,
    input logic        i_last
);
    import hle_pkg::*;

    // No request is taken while a result is offered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_valid && i_in_ready && i_out_valid)) else $error("request taken during result");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind))
        else $error("stalled result changed");

    // Acks and query answers are single results.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_ACK || i_kind == KIND_QUERY) |-> i_last)
        else $error("single result without last");

    // First index never exceeds the count.
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_QUERY |-> i_first <= i_count)
        else $error("first index beyond count");
endmodule

bind holiday_list_extractor_core hle_checker u_hle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (in_ch.valid),
    .i_in_ready  (in_ch.ready),
    .i_out_valid (out_ch.valid),
    .i_out_ready (out_ch.ready),
    .i_kind      (out_ch.kind),
    .i_count     (out_ch.entry_count),
    .i_first     (out_ch.first_index),
    .i_last      (out_ch.last)
);

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Holiday list extractor testbench
// Streams JSON reply bytes, clears, date queries and entry reads into the
// core, predicts the results from an independent behavioural copy of the
// parser and table or takes them from a directed row, and compares each result field by field.
// ---------------------------------------------------------------------------
module tb_top;
    import hle_pkg::*;

    localparam int NameCap    = NameSlotDef - 1;
    localparam int IdleLimit  = 5000;
    localparam int HoldCycle  = 120;
    localparam int HoldLength = 600;
    localparam int ItemTarget = 340;

    typedef struct {
        logic [2:0]  op;
        logic [7:0]  data;
        logic [13:0] qy;
        logic [3:0]  qm;
        logic [4:0]  qd;
        logic [6:0]  idx;
    } req_t;

    typedef struct {
        int kind;
        int count;
        int first;
        int hit;
        int hidx;
        int year;
        int month;
        int day;
        int ch;
        int last;
    } res_t;

    // Directed row: a body text is expanded to one request per byte.
    typedef struct {
        logic [2:0]  op;
        string       text;
        logic [13:0] qy;
        logic [3:0]  qm;
        logic [4:0]  qd;
        logic [6:0]  idx;
        bit          typed;
        int          kind;
        int          count;
    } dir_row_t;

    logic i_clk;
    logic i_rst_n;
    hle_in_if  in_ch ();
    hle_out_if out_ch ();

    holiday_list_extractor_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Predicted table and parser state.
    int     tab_year  [MaxEntriesDef];
    int     tab_month [MaxEntriesDef];
    int     tab_day   [MaxEntriesDef];
    int     tab_len   [MaxEntriesDef];
    int     tab_chars [MaxEntriesDef][NameCap];
    int     tab_count;
    bit     tab_full;
    t_phase phase;
    int     key_pos;
    int     date_pos;
    int     pend_y;
    int     pend_m;
    int     pend_d;
    bit     date_ok;
    int     name_fill;
    int     name_trim;

    res_t   expected_results [$];
    int     fail_count;
    bit     quiet;
    int     idle_cycles;
    int     rx_cycles;
    int     sent_items;

    string  date_key = "\"date\":\"";
    string  name_key = "\"name\":\"";

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Longest prefix of the key that ends the matched text plus the new byte.
    function automatic int key_step(input string key, input int p, input logic [7:0] c);
        int  k;
        bit  same;
        if (p > 7) p = 7;
        for (k = p + 1; k > 0; k--) begin
            if (key[k - 1] != c) continue;
            same = 1'b1;
            for (int j = 0; j < k - 1; j++) begin
                if (key[j] != key[p - k + 1 + j]) same = 1'b0;
            end
            if (same) return k;
        end
        return 0;
    endfunction

    function automatic void parser_clear();
        phase     = PH_SEEK_DATE;
        key_pos   = 0;
        date_pos  = 0;
        pend_y    = 0;
        pend_m    = 0;
        pend_d    = 0;
        date_ok   = 1'b1;
        name_fill = 0;
        name_trim = 0;
    endfunction

    // One character of YYYY-MM-DD; separators are not checked.
    function automatic void date_step(input logic [7:0] b);
        int v;
        v = 0;
        if (date_pos != 4 && date_pos != 7) begin
            if (b >= "0" && b <= "9") v = b - "0";
            else date_ok = 1'b0;
        end
        if (date_pos < 4) begin
            pend_y = (pend_y * 10 + v) & 16'h3FFF;
        end else if (date_pos == 5) begin
            if (v > 1) begin
                date_ok = 1'b0;
                pend_m  = 0;
            end else pend_m = v * 10;
        end else if (date_pos == 6) begin
            v = v + pend_m;
            if (v < 1 || v > 12) begin
                date_ok = 1'b0;
                v = 0;
            end
            pend_m = v;
        end else if (date_pos == 8) begin
            if (v > 3) begin
                date_ok = 1'b0;
                pend_d  = 0;
            end else pend_d = v * 10;
        end else if (date_pos == 9) begin
            v = v + pend_d;
            if (v < 1 || v > 31) begin
                date_ok = 1'b0;
                v = 0;
            end
            pend_d = v;
        end
        date_pos++;
        if (date_pos >= 10) begin
            phase    = PH_SEEK_NAME;
            key_pos  = 0;
            date_pos = 0;
        end
    endfunction

    // Closing quote of a name: append the entry when it is well formed.
    function automatic void name_close();
        if (date_ok && name_trim > 0 && tab_count < MaxEntriesDef) begin
            tab_year[tab_count]  = pend_y;
            tab_month[tab_count] = pend_m;
            tab_day[tab_count]   = pend_d;
            tab_len[tab_count]   = name_trim;
            tab_count++;
            if (tab_count >= MaxEntriesDef) tab_full = 1'b1;
        end
        parser_clear();
        // The quote also starts the next date key.
        key_pos = 1;
    endfunction

    function automatic void body_step(input logic [7:0] b);
        if (tab_full || tab_count >= MaxEntriesDef) return;
        case (phase)
            PH_SEEK_DATE: begin
                key_pos = key_step(date_key, key_pos, b);
                if (key_pos >= 8) begin
                    phase    = PH_DATE;
                    key_pos  = 0;
                    date_pos = 0;
                    pend_y   = 0;
                    pend_m   = 0;
                    pend_d   = 0;
                    date_ok  = 1'b1;
                end
            end
            PH_DATE: begin
                date_step(b);
            end
            PH_SEEK_NAME: begin
                key_pos = key_step(name_key, key_pos, b);
                if (key_pos >= 8) begin
                    phase     = PH_NAME;
                    key_pos   = 0;
                    name_fill = 0;
                    name_trim = 0;
                end
            end
            default: begin
                if (b == 8'h22) begin
                    name_close();
                end else if (b >= 32 && b <= 126 && name_fill < NameCap) begin
                    tab_chars[tab_count][name_fill] = b;
                    name_fill++;
                    if (b != 8'h20) name_trim = name_fill;
                end
            end
        endcase
    endfunction

    // Advance the predicted state by one request and append its results.
    task automatic predict_results(input req_t r, ref res_t q[$]);
        res_t o;
        int   qkey;
        int   k;
        int   n;
        o = '{default: 0};
        o.last = 1;
        case (r.op)
            OP_BYTE: begin
                body_step(r.data);
            end
            OP_END, OP_CLEAR: begin
                if (r.op == OP_CLEAR) begin
                    tab_count = 0;
                    tab_full  = 1'b0;
                end
                parser_clear();
                o.kind  = KIND_ACK;
                o.count = tab_count;
                q.push_back(o);
            end
            OP_QUERY: begin
                qkey    = (int'(r.qy) * 12 + int'(r.qm)) * 31 + int'(r.qd);
                o.kind  = KIND_QUERY;
                o.count = tab_count;
                o.first = tab_count;
                for (int i = 0; i < tab_count; i++) begin
                    k = (tab_year[i] * 12 + tab_month[i]) * 31 + tab_day[i];
                    if (o.first == tab_count && k >= qkey) o.first = i;
                    if (!o.hit && tab_year[i] == r.qy && tab_month[i] == r.qm &&
                        tab_day[i] == r.qd) begin
                        o.hit  = 1;
                        o.hidx = i;
                    end
                end
                q.push_back(o);
            end
            OP_READ: begin
                o.count = tab_count;
                if (r.idx >= tab_count) begin
                    o.kind = KIND_RANGE;
                    q.push_back(o);
                end else begin
                    o.kind  = KIND_ENTRY;
                    o.year  = tab_year[r.idx];
                    o.month = tab_month[r.idx];
                    o.day   = tab_day[r.idx];
                    n = (tab_len[r.idx] > ResultLimit) ? ResultLimit : tab_len[r.idx];
                    if (n == 0) begin
                        q.push_back(o);
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            o.ch   = tab_chars[r.idx][i];
                            o.last = (i == n - 1);
                            q.push_back(o);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Offer one request, with an occasional gap first, and predict on acceptance.
    task automatic send_request(input req_t r, input bit typed, input res_t typed_res);
        res_t scratch [$];
        if (!quiet && $urandom_range(0, 9) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= r.op;
        in_ch.data_byte   <= r.data;
        in_ch.query_year  <= r.qy;
        in_ch.query_month <= r.qm;
        in_ch.query_day   <= r.qd;
        in_ch.entry_index <= r.idx;
        do @(posedge i_clk); while (!in_ch.ready);
        sent_items++;
        if (typed) begin
            predict_results(r, scratch);
            expected_results.push_back(typed_res);
        end else begin
            predict_results(r, expected_results);
        end
    endtask

    function automatic req_t rand_req(input logic [2:0] op);
        req_t r;
        r.op   = op;
        r.data = 8'($urandom_range(0, 255));
        r.qy   = 14'($urandom_range(0, 16383));
        r.qm   = 4'($urandom_range(0, 15));
        r.qd   = 5'($urandom_range(0, 31));
        r.idx  = 7'($urandom_range(0, 127));
        return r;
    endfunction

    task automatic send_text(input string s);
        req_t r;
        res_t none;
        none = '{default: 0};
        for (int i = 0; i < s.len(); i++) begin
            r      = rand_req(OP_BYTE);
            r.data = s[i];
            send_request(r, 1'b0, none);
        end
    endtask

    // A holiday record with random content, now and then damaged.
    function automatic string make_record();
        string s;
        string d;
        int    n;
        logic [7:0] c;
        s = "";
        if ($urandom_range(0, 4) == 0) s = "{\"x\":\"\"da";
        d = $sformatf("%04d-%02d-%02d", $urandom_range(0, 9999), $urandom_range(1, 12),
                      $urandom_range(1, 31));
        if ($urandom_range(0, 7) == 0) begin
            c = 8'($urandom_range(0, 255));
            d.putc(int'($urandom_range(0, 9)), c);
        end
        s = {s, date_key, d, "\",\"localName\":\"x\",", name_key};
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0:       c = 8'h20;
                1:       c = 8'($urandom_range(128, 255));
                2:       c = 8'($urandom_range(0, 31));
                default: c = 8'($urandom_range(35, 126));
            endcase
            s = {s, string'(c)};
        end
        if ($urandom_range(0, 5) == 0) s = {s, "   "};
        return {s, "\"}"};
    endfunction

    dir_row_t dir_tab [$];

    // Main stimulus.
    initial begin
        req_t r;
        res_t tr;
        int   p;
        fail_count  = 0;
        quiet       = 1'b0;
        sent_items  = 0;
        tab_count   = 0;
        tab_full    = 1'b0;
        parser_clear();
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.opcode      <= OP_BYTE;
        in_ch.data_byte   <= '0;
        in_ch.query_year  <= '0;
        in_ch.query_month <= '0;
        in_ch.query_day   <= '0;
        in_ch.entry_index <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: empty table, special cases of the parser, extremes.
        dir_tab.push_back('{OP_READ, "", 0, 0, 0, 0, 1, KIND_RANGE, 0});
        dir_tab.push_back('{OP_QUERY, "", 0, 0, 0, 0, 1, KIND_QUERY, 0});
        dir_tab.push_back('{OP_END, "", 0, 0, 0, 0, 1, KIND_ACK, 0});
        dir_tab.push_back('{OP_BYTE, "[{\"date\":\"2024-01-01\",\"name\":\"New Year  \"}",
                            0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{OP_BYTE, "{\"date\":\"20x4-13-01\",\"name\":\"Bad\"}",
                            0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{OP_BYTE, {"\"date\":\"9999-12-31\",\"name\":\"",
                            "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmn\""},
                            0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{OP_BYTE, "\"date\":\"0000-12-31\"\"name\":\"A\001\377~ B\"",
                            0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{OP_BYTE, "\"date\":\"2020-02-02\",\"name\":\"   \"",
                            0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{OP_BYTE, "\"date\":\"\"name\":\"ab\"name\":\"Z\"",
                            0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{OP_BYTE, "\"date\":\"2021x03y04\",\"name\":\"Sep\"",
                            0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{OP_BYTE, "\"date\":\"2022-05-0", 0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{OP_END, "", 0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{3'd5, "", 0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{3'd7, "", 0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{OP_READ, "", 0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{OP_READ, "", 0, 0, 0, 1, 0, 0, 0});
        dir_tab.push_back('{OP_READ, "", 0, 0, 0, 2, 0, 0, 0});
        dir_tab.push_back('{OP_READ, "", 0, 0, 0, 3, 0, 0, 0});
        dir_tab.push_back('{OP_READ, "", 0, 0, 0, 127, 0, 0, 0});
        dir_tab.push_back('{OP_QUERY, "", 2024, 1, 1, 0, 0, 0, 0});
        dir_tab.push_back('{OP_QUERY, "", 9999, 12, 31, 0, 0, 0, 0});
        dir_tab.push_back('{OP_QUERY, "", 16383, 15, 31, 0, 0, 0, 0});
        dir_tab.push_back('{OP_QUERY, "", 0, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{OP_CLEAR, "", 0, 0, 0, 0, 1, KIND_ACK, 0});
        dir_tab.push_back('{OP_READ, "", 0, 0, 0, 127, 1, KIND_RANGE, 0});

        foreach (dir_tab[i]) begin
            if (dir_tab[i].op == OP_BYTE) begin
                send_text(dir_tab[i].text);
            end else begin
                r     = rand_req(dir_tab[i].op);
                r.qy  = dir_tab[i].qy;
                r.qm  = dir_tab[i].qm;
                r.qd  = dir_tab[i].qd;
                r.idx = dir_tab[i].idx;
                tr       = '{default: 0};
                tr.kind  = dir_tab[i].kind;
                tr.count = dir_tab[i].count;
                tr.last  = 1;
                send_request(r, dir_tab[i].typed, tr);
            end
        end

        // Random part: records and single requests up to the item target.
        tr = '{default: 0};
        for (int n = 0; sent_items < ItemTarget; n++) begin
            if (sent_items > ItemTarget - 30) quiet = 1'b1;
            p = $urandom_range(0, 99);
            if (p < 68) begin
                send_text(make_record());
            end else if (p < 76) begin
                repeat ($urandom_range(1, 6)) send_request(rand_req(OP_BYTE), 1'b0, tr);
            end else if (p < 79) begin
                send_request(rand_req(OP_END), 1'b0, tr);
            end else if (p < 81 && n > 2) begin
                send_request(rand_req(OP_CLEAR), 1'b0, tr);
            end else if (p < 90) begin
                r = rand_req(OP_QUERY);
                if (tab_count > 0 && p[0]) begin
                    p    = $urandom_range(0, tab_count - 1);
                    r.qy = 14'(tab_year[p]);
                    r.qm = 4'(tab_month[p]);
                    r.qd = 5'(tab_day[p] + int'($urandom_range(0, 1)));
                end
                send_request(r, 1'b0, tr);
            end else if (p < 98) begin
                r = rand_req(OP_READ);
                if (tab_count > 0 && p[0]) r.idx = 7'($urandom_range(0, tab_count - 1));
                send_request(r, 1'b0, tr);
            end else begin
                send_request(rand_req(3'($urandom_range(5, 7))), 1'b0, tr);
            end
        end
        in_ch.valid <= 1'b0;

        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Receiver: random stalls, one long hold-off, and none near the end.
    initial begin
        out_ch.ready <= 1'b0;
        rx_cycles = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            rx_cycles++;
            if (rx_cycles == HoldCycle) begin
                out_ch.ready <= 1'b0;
                repeat (HoldLength) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Compare each result request with the oldest expectation.
    always @(posedge i_clk) begin
        res_t e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected");
                fail_count++;
            end else begin
                e = expected_results.pop_front();
                check_field("kind", e.kind, out_ch.kind);
                check_field("entry_count", e.count, out_ch.entry_count);
                check_field("first_index", e.first, out_ch.first_index);
                check_field("day_hit", e.hit, out_ch.day_hit);
                check_field("hit_index", e.hidx, out_ch.hit_index);
                check_field("entry_year", e.year, out_ch.entry_year);
                check_field("entry_month", e.month, out_ch.entry_month);
                check_field("entry_day", e.day, out_ch.entry_day);
                check_field("name_char", e.ch, out_ch.name_char);
                check_field("last", e.last, out_ch.last);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

/* holiday_list_extractor_core.f */
design/hle_pkg.sv
design/hle_if.sv
design/hle_ram.sv
design/hle_ctrl.sv
design/hle_dp.sv
design/holiday_list_extractor_core.sv
design/hle_checker.sv
test/tb_top.sv
